// ===== src/ucalloc_pkg.sv =====
package ucalloc_pkg;

  localparam int CORE_COUNT     = 4;
  localparam int LOAD_FRAC_BITS = 16;

  localparam int TIME_W   = 16;
  localparam int CIDX_W   = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int CNT_MAX  = (LOAD_FRAC_BITS > CORE_COUNT) ? LOAD_FRAC_BITS : CORE_COUNT;
  localparam int CNT_W    = $clog2(CNT_MAX);

  localparam logic [3:0] FREQ_STEP_MIN = 4'd6;
  localparam logic [3:0] FREQ_STEP_MAX = 4'd15;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] exec_time;
    logic [TIME_W-1:0] period;
  } task_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] core_index;
    logic [3:0] freq_step;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_APPLY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              search_step;
    logic              apply;
    logic              out_load;
    logic [CIDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/utilization_core_allocator_top.sv =====
// channel  | direction | handshake                 | payload
// task     | in        | task_valid/task_stall     | task_item (exec_time, period)
// result   | out       | result_valid/result_stall | result_data (status, core_index, freq_step)
// config   | in        | cfg_we                    | cfg_wdata (fit_mode)
//
// one task at a time: accept, LOAD_FRAC_BITS divide steps (one quotient bit each), a search over
// the CORE_COUNT core loads, an update and a result step; a rejected task skips search and update
// the result register holds one finished transaction, so a new task is taken while it waits
// a finished task holds in the result cycle while the previous result is still stalled
// reset is synchronous: loads clear, fit_mode returns to 1
module utilization_core_allocator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 task_valid,
  output logic                 task_stall,
  input  ucalloc_pkg::task_t   task_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output ucalloc_pkg::result_t result_data
);
  import ucalloc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ucalloc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_stall (task_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ucalloc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .task_item    (task_item),
    .result_data  (result_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== src/ucalloc_ctrl.sv =====
module ucalloc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              task_valid,
  output logic              task_stall,
  input  ucalloc_pkg::sts_t sts,
  output ucalloc_pkg::cmd_t cmd
);
  import ucalloc_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd             = '0;
    cmd.idx         = cnt[CIDX_W-1:0];
    task_stall      = 1'b1;
    case (state)
      S_IDLE: begin
        task_stall = 1'b0;
        if (task_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(LOAD_FRAC_BITS - 1)) begin
          cnt_next   = '0;
          // rejected tasks skip the search and report current loads
          state_next = sts.invalid ? S_FIN : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        cnt_next        = cnt + 1'b1;
        if (cnt == CNT_W'(CORE_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_fin_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !sts.out_busy) |=> state == S_IDLE)
    else $error("result stage did not release");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("waiting result overwritten");

  a_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DIV)
    else $error("accepted task did not start divide");

endmodule

// ===== src/ucalloc_dp.sv =====
module ucalloc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  ucalloc_pkg::task_t   task_item,
  output ucalloc_pkg::result_t result_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  ucalloc_pkg::cmd_t    cmd,
  output ucalloc_pkg::sts_t    sts
);
  import ucalloc_pkg::*;

  localparam int LW = LOAD_FRAC_BITS;

  logic [TIME_W-1:0] divisor;
  logic [TIME_W:0]   rem;
  logic [LW-1:0]     quo;
  logic              invalid;
  logic              fit_mode;
  logic [LW-1:0]     core_load [CORE_COUNT];
  logic [LW-1:0]     max_load;
  logic [CIDX_W-1:0] best_idx;
  logic [LW-1:0]     best_load;
  logic              best_valid;
  logic              placed;

  logic [TIME_W:0]   rem_sh;
  logic              rem_ge;
  logic [LW-1:0]     cur_load;
  logic [LW:0]       cur_sum;
  logic              take;
  logic [LW:0]       best_sum;
  logic              best_fit;
  logic [LW+3:0]     prod;
  logic [4:0]        step_raw;
  logic [3:0]        step;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem[TIME_W-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  assign cur_load = core_load[cmd.idx];
  assign cur_sum  = {1'b0, cur_load} + {1'b0, quo};

  always_comb begin
    if (fit_mode == 1'b0) begin
      take = !cur_sum[LW] && (!best_valid || cur_load > best_load);
    end else begin
      take = !best_valid || cur_load < best_load;
    end
  end

  assign best_sum = {1'b0, best_load} + {1'b0, quo};
  assign best_fit = best_valid && !best_sum[LW];

  // 15 * max load as shift and subtract
  assign prod     = {max_load, 4'b0} - {4'b0, max_load};
  assign step_raw = {1'b0, prod[LW+3:LW]} + 5'd1;
  always_comb begin
    if (step_raw < {1'b0, FREQ_STEP_MIN}) begin
      step = FREQ_STEP_MIN;
    end else if (step_raw > {1'b0, FREQ_STEP_MAX}) begin
      step = FREQ_STEP_MAX;
    end else begin
      step = step_raw[3:0];
    end
  end

  assign sts.invalid  = invalid;
  assign sts.out_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= 1'b1;
      result_valid <= 1'b0;
      max_load     <= '0;
      best_valid   <= 1'b0;
      placed       <= 1'b0;
      for (int i = 0; i < CORE_COUNT; i++) begin
        core_load[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        fit_mode <= cfg_wdata;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end
      if (cmd.load) begin
        best_valid <= 1'b0;
        placed     <= 1'b0;
      end
      if (cmd.search_step && take) begin
        best_valid <= 1'b1;
      end
      if (cmd.apply && best_fit) begin
        core_load[best_idx] <= best_sum[LW-1:0];
        placed              <= 1'b1;
        // loads only grow, so a running max tracks the highest load
        if (best_sum[LW-1:0] > max_load) begin
          max_load <= best_sum[LW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= task_item.period;
      rem     <= {1'b0, task_item.exec_time};
      quo     <= '0;
      invalid <= task_item.exec_time >= task_item.period;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo <= {quo[LW-2:0], rem_ge};
    end
    if (cmd.search_step && take) begin
      best_idx  <= cmd.idx;
      best_load <= cur_load;
    end
    if (cmd.out_load) begin
      if (invalid) begin
        result_data.status <= ST_INVALID;
      end else if (placed) begin
        result_data.status <= ST_PLACED;
      end else begin
        result_data.status <= ST_NO_FIT;
      end
      result_data.core_index <= (placed && !invalid) ? 2'(best_idx) : 2'd0;
      result_data.freq_step  <= step;
    end
  end

  a_core_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.status != ST_PLACED) |-> result_data.core_index == 2'd0)
    else $error("core index set on unplaced task");

  a_step_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.freq_step >= FREQ_STEP_MIN)
    else $error("frequency step below floor");

  a_max_tracks: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && best_fit) |=> max_load >= $past(best_sum[LW-1:0]))
    else $error("max load missed an update");

endmodule
